@@ design/uer_pkg.sv @@
// uer_pkg: shared types, codes and constants of the ultrasonic echo ranger
// no dependencies; used by the channel interfaces and all design modules

package uer_pkg;

   localparam int TIME_W  = 32;
   localparam int DIST_W  = 27;
   localparam int SKIP_W  = 16;
   localparam int WIDTH_W = 8;
   localparam int IDX_W   = 1;
   localparam int CSR_W   = 16;
   localparam int PROD_W  = 63;

   // operation codes carried in the op field
   localparam logic OP_TRIGGER = 1'b0;
   localparam logic OP_EDGE    = 1'b1;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_ESCAPE_LIMIT  = 1'b0;
   localparam logic [IDX_W-1:0] REG_TRIGGER_WIDTH = 1'b1;

   localparam logic [SKIP_W-1:0]  ESCAPE_LIMIT_RESET  = 16'd7000;
   localparam logic [WIDTH_W-1:0] TRIGGER_WIDTH_RESET = 8'd10;

   // x / 58 == ((x >> 1) * ceil(2^36 / 29)) >> 36, exact for every 32-bit x
   localparam logic [31:0] DIV29_RECIP = 32'd2369637129;
   localparam int          DIV29_SHIFT = 36;

   typedef enum logic [1:0] {
      PHASE_WAIT_RISE = 2'd0,
      PHASE_WAIT_FALL = 2'd1,
      PHASE_COMPLETE  = 2'd2
   } phase_type;

   // per-item result traveling down the pipeline
   typedef struct packed {
      logic                fire_trigger;
      logic [WIDTH_W-1:0]  pulse_width;
      logic                measure_done;
      logic [TIME_W-1:0]   echo_duration;
      phase_type           phase;
   } item_result_type;

endpackage

@@ design/uer_channels.sv @@
// uer_channels: valid/ready channel interfaces for requests, results and
// register writes; depends on uer_pkg for field widths

interface uer_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic                       edge_rising;
   logic [uer_pkg::TIME_W-1:0] capture_time;

   modport source(output valid, op, edge_rising, capture_time, input ready);
   modport sink(input valid, op, edge_rising, capture_time, output ready);
endinterface

interface uer_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        fire_trigger;
   logic [uer_pkg::WIDTH_W-1:0] pulse_width;
   logic                        measure_done;
   logic [uer_pkg::TIME_W-1:0]  echo_duration;
   logic [uer_pkg::DIST_W-1:0]  distance_cm;
   logic [1:0]                  phase;

   modport source(output valid, fire_trigger, pulse_width, measure_done,
                  echo_duration, distance_cm, phase, input ready);
   modport sink(input valid, fire_trigger, pulse_width, measure_done,
                echo_duration, distance_cm, phase, output ready);
endinterface

interface uer_csr_if;
   logic                      valid;
   logic                      ready;
   logic [uer_pkg::IDX_W-1:0] index;
   logic [uer_pkg::CSR_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

@@ design/uer_ctrl.sv @@
// uer_ctrl: configuration registers, ranging state and the first pipeline stage
// depends on uer_pkg and the channel interfaces in uer_channels

module uer_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   uer_csr_if.sink                  csr_if,
   uer_req_if.sink                  req_if,
   input  logic                     next_load,
   output logic                     stage_valid,
   output uer_pkg::item_result_type stage_data
);

   logic [uer_pkg::SKIP_W-1:0]  escape_limit_ff;
   logic [uer_pkg::WIDTH_W-1:0] trigger_width_ff;

   uer_pkg::phase_type          phase_ff, phase_in;
   logic [uer_pkg::TIME_W-1:0]  rise_stamp_ff, rise_stamp_in;
   logic [uer_pkg::SKIP_W-1:0]  skip_count_ff, skip_count_in;
   logic [uer_pkg::TIME_W-1:0]  duration_ff, duration_in;

   logic                        valid_ff;
   uer_pkg::item_result_type    data_ff, data_in;
   logic                        load;
   logic                        accept;

   assign csr_if.ready = 1'b1;
   assign load         = !valid_ff || next_load;
   assign req_if.ready = load;
   assign accept       = req_if.valid && load;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_limit_ff  <= uer_pkg::ESCAPE_LIMIT_RESET;
         trigger_width_ff <= uer_pkg::TRIGGER_WIDTH_RESET;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            uer_pkg::REG_ESCAPE_LIMIT: begin
               escape_limit_ff <= csr_if.data[uer_pkg::SKIP_W-1:0];
            end
            uer_pkg::REG_TRIGGER_WIDTH: begin
               trigger_width_ff <= csr_if.data[uer_pkg::WIDTH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      rise_stamp_in = rise_stamp_ff;
      skip_count_in = skip_count_ff;
      duration_in   = duration_ff;
      data_in       = '0;

      if (req_if.op == uer_pkg::OP_TRIGGER) begin
         // while the falling edge is awaited, requests are skipped up to the limit
         if (phase_ff == uer_pkg::PHASE_WAIT_FALL && skip_count_ff < escape_limit_ff) begin
            skip_count_in = skip_count_ff + {{(uer_pkg::SKIP_W-1){1'b0}}, 1'b1};
         end else begin
            skip_count_in        = '0;
            phase_in             = uer_pkg::PHASE_WAIT_RISE;
            data_in.fire_trigger = 1'b1;
            data_in.pulse_width  = trigger_width_ff;
         end
      end else begin
         if (phase_ff == uer_pkg::PHASE_WAIT_RISE && req_if.edge_rising) begin
            rise_stamp_in = req_if.capture_time;
            phase_in      = uer_pkg::PHASE_WAIT_FALL;
         end else if (phase_ff == uer_pkg::PHASE_WAIT_FALL && !req_if.edge_rising) begin
            duration_in          = req_if.capture_time - rise_stamp_ff;
            phase_in             = uer_pkg::PHASE_COMPLETE;
            data_in.measure_done = 1'b1;
         end
      end

      data_in.echo_duration = duration_in;
      data_in.phase         = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= uer_pkg::PHASE_WAIT_RISE;
         rise_stamp_ff <= '0;
         skip_count_ff <= '0;
         duration_ff   <= '0;
         valid_ff      <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff      <= phase_in;
            rise_stamp_ff <= rise_stamp_in;
            skip_count_ff <= skip_count_in;
            duration_ff   <= duration_in;
         end
         if (load) begin
            valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

@@ design/uer_div58.sv @@
// uer_div58: second pipeline stage, reciprocal multiply for duration / 58
// depends on uer_pkg

module uer_div58 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          prev_valid,
   input  uer_pkg::item_result_type      prev_data,
   output logic                          prev_load,
   input  logic                          next_load,
   output logic                          stage_valid,
   output uer_pkg::item_result_type      stage_data,
   output logic [uer_pkg::DIST_W-1:0]    quotient
);

   logic                            valid_ff;
   uer_pkg::item_result_type        data_ff;
   logic [uer_pkg::PROD_W-1:0]      prod_ff, prod_in;
   logic [uer_pkg::TIME_W-2:0]      half_duration;
   logic                            load;

   assign load      = !valid_ff || next_load;
   assign prev_load = load;

   // divide by 2 first so a 32-bit reciprocal of 29 stays exact
   assign half_duration = prev_data.echo_duration[uer_pkg::TIME_W-1:1];
   assign prod_in = {32'd0, half_duration} * {31'd0, uer_pkg::DIV29_RECIP};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && prev_valid) begin
         data_ff <= prev_data;
         prod_ff <= prod_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;
   assign quotient    = prod_ff[uer_pkg::PROD_W-1:uer_pkg::DIV29_SHIFT];

endmodule

@@ design/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: trigger control, echo edge timing and distance.
// Throughput: one item per cycle while rsp_if.ready holds; the three stages drain independently.
// State updates at the request transfer; the distance multiply follows in stage 2.
// Reset clears phase, stamps, skip count and the last measurement, and
// loads escape_limit = 7000 and trigger_width_us = 10.

module ultrasonic_echo_ranger (
   input  logic      clock,
   input  logic      reset,
   uer_csr_if.sink   csr_if,
   uer_req_if.sink   req_if,
   uer_rsp_if.source rsp_if
);

   logic                          s1_valid, s1_load;
   uer_pkg::item_result_type      s1_data;
   logic                          s2_valid;
   uer_pkg::item_result_type      s2_data;
   logic [uer_pkg::DIST_W-1:0]    s2_quotient;

   logic                          valid_ff;
   uer_pkg::item_result_type      data_ff;
   logic [uer_pkg::DIST_W-1:0]    distance_ff;
   logic                          load;

   uer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_if      (csr_if),
      .req_if      (req_if),
      .next_load   (s1_load),
      .stage_valid (s1_valid),
      .stage_data  (s1_data)
   );

   uer_div58 u_div58 (
      .clock       (clock),
      .reset       (reset),
      .prev_valid  (s1_valid),
      .prev_data   (s1_data),
      .prev_load   (s1_load),
      .next_load   (load),
      .stage_valid (s2_valid),
      .stage_data  (s2_data),
      .quotient    (s2_quotient)
   );

   assign load = !valid_ff || rsp_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         distance_ff <= '0;
      end else if (load) begin
         valid_ff <= s2_valid;
         // output register doubles as the last-distance state
         if (s2_valid && s2_data.measure_done) begin
            distance_ff <= s2_quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && s2_valid) begin
         data_ff <= s2_data;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.fire_trigger  = data_ff.fire_trigger;
   assign rsp_if.pulse_width   = data_ff.pulse_width;
   assign rsp_if.measure_done  = data_ff.measure_done;
   assign rsp_if.echo_duration = data_ff.echo_duration;
   assign rsp_if.distance_cm   = distance_ff;
   assign rsp_if.phase         = data_ff.phase;

endmodule
